FILE: hdl/ogsr_pkg.sv
package ogsr_pkg;

    // Default storage size of the grid
    localparam int unsigned DEF_MAX_COLS = 64;
    localparam int unsigned DEF_MAX_ROWS = 64;

    // Field widths
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned CELL_W   = 6;
    localparam int unsigned WORLD_W  = 32;
    localparam int unsigned EXTENT_W = 31;
    localparam int unsigned GRID_W   = 7;
    localparam int unsigned R2_W     = EXTENT_W + 1;
    localparam int unsigned SQ_W     = 2 * R2_W;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE   = 3'd4;

    // Register reset values
    localparam logic [GRID_W-1:0]   RST_GRID_WIDTH  = 7'd64;
    localparam logic [GRID_W-1:0]   RST_GRID_HEIGHT = 7'd64;
    localparam logic [EXTENT_W-1:0] RST_CELL_SIZE   = 31'd65536;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_SET    = 2'd0,
        CMD_QUERY  = 2'd1,
        CMD_RECT   = 2'd2,
        CMD_CIRCLE = 2'd3
    } t_cmd_e;

    // One command transfer
    typedef struct packed {
        logic [CMD_W-1:0]           cmd;
        logic [CELL_W-1:0]          row;
        logic [CELL_W-1:0]          col;
        logic                       occ;
        logic signed [WORLD_W-1:0]  center_x;
        logic signed [WORLD_W-1:0]  center_y;
        logic [EXTENT_W-1:0]        rect_width;
        logic [EXTENT_W-1:0]        rect_height;
        logic [EXTENT_W-1:0]        radius;
    } t_cmd_in;

    // One result transfer
    typedef struct packed {
        logic occupied;
        logic in_range;
    } t_result;

endpackage

FILE: hdl/occupancy_grid_shape_raster.sv
// Occupancy grid with cell set/query and rectangle/circle rasterization.
//
// Command channel: a transfer happens at a clock edge with start high and busy
// low. Result channel: o_valid is high for exactly one cycle per command and
// o_result is taken at the end of that cycle; the receiver has no stall.
// Configuration: i_cfg_we writes register i_cfg_idx at the edge (grid width/height, origin x/y,
// cell size); the user must write only while the block is idle: the block does not enforce it.
//
// Set and query: the result strobe comes in the cycle after the transfer and
// busy stays low, so a new command can be taken every cycle. A query reads
// the one-bit-wide cell memory through a registered read.
// Rectangle and circle: busy goes high, a setup state computes the sweep bounds,
// then the sweep visits one cell per cycle through a three-stage compare pipeline
// that writes the memory; the strobe comes once the sweep of all cells in use
// and the pipeline drain are done. busy drops with the strobe, so no new command
// is taken while a shape command is in progress.
//
// Reset: configuration returns to its defaults and a clearing pass writes
// zero to all MAX_ROWS * MAX_COLS memory entries, one per cycle; busy is high
// during the pass.
module occupancy_grid_shape_raster #(
    parameter int unsigned MAX_COLS = ogsr_pkg::DEF_MAX_COLS,
    parameter int unsigned MAX_ROWS = ogsr_pkg::DEF_MAX_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  ogsr_pkg::t_cmd_in                i_cmd,
    output logic                             o_valid,
    output ogsr_pkg::t_result                o_result,
    input  logic                             i_cfg_we,
    input  logic [ogsr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [ogsr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import ogsr_pkg::*;

    localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int unsigned IW    = (CW > RW) ? CW : RW;
    // doubled cell centers reach 2^(IW+33) in magnitude
    localparam int unsigned PW    = IW + 35;
    localparam int unsigned UC    = $clog2(MAX_COLS + 1);
    localparam int unsigned UR    = $clog2(MAX_ROWS + 1);
    localparam int unsigned U0    = (UC > UR) ? UC : UR;
    localparam int unsigned UW    = (U0 > GRID_W) ? U0 : GRID_W;

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SETUP = 5'b00100,
        S_SWEEP = 5'b01000,
        S_DRAIN = 5'b10000
    } t_state_e;

    t_state_e r_state, n_state;

    // Configuration registers
    logic [GRID_W-1:0]          r_grid_width, r_grid_height;
    logic signed [WORLD_W-1:0]  r_origin_x, r_origin_y;
    logic [EXTENT_W-1:0]        r_cell_size;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= RST_GRID_WIDTH;
            r_grid_height <= RST_GRID_HEIGHT;
            r_origin_x    <= '0;
            r_origin_y    <= '0;
            r_cell_size   <= RST_CELL_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[GRID_W-1:0];
                REG_GRID_HEIGHT: r_grid_height <= i_cfg_data[GRID_W-1:0];
                REG_ORIGIN_X:    r_origin_x    <= $signed(i_cfg_data[WORLD_W-1:0]);
                REG_ORIGIN_Y:    r_origin_y    <= $signed(i_cfg_data[WORLD_W-1:0]);
                REG_CELL_SIZE:   r_cell_size   <= i_cfg_data[EXTENT_W-1:0];
                default: ;
            endcase
        end
    end

    // Columns and rows in use, clipped to storage
    logic [UW-1:0] nc, nr;
    assign nc = (UW'(r_grid_width) > UW'(MAX_COLS)) ? UW'(MAX_COLS) : UW'(r_grid_width);
    assign nr = (UW'(r_grid_height) > UW'(MAX_ROWS)) ? UW'(MAX_ROWS) : UW'(r_grid_height);

    // Command decode
    logic          acc, is_cell, cell_in_range;
    logic [AW-1:0] cell_addr;

    assign busy          = (r_state != S_IDLE);
    assign acc           = start && !busy;
    assign is_cell       = i_cmd.cmd inside {CMD_SET, CMD_QUERY};
    assign cell_in_range = (UW'(i_cmd.row) < nr) && (UW'(i_cmd.col) < nc);
    assign cell_addr     = AW'(32'(i_cmd.row) * 32'(MAX_COLS) + 32'(i_cmd.col));

    // Shape operands latched at transfer
    logic                 r_is_rect;
    logic signed [PW-1:0] r_cx2, r_cy2;
    logic [EXTENT_W-1:0]  r_w, r_h;
    logic [R2_W-1:0]      r_r2;

    always_ff @(posedge i_clk) begin
        if (acc && !is_cell) begin
            r_is_rect <= (i_cmd.cmd == CMD_RECT);
            r_cx2     <= PW'($signed(i_cmd.center_x)) <<< 1;
            r_cy2     <= PW'($signed(i_cmd.center_y)) <<< 1;
            r_w       <= i_cmd.rect_width;
            r_h       <= i_cmd.rect_height;
            r_r2      <= {i_cmd.radius, 1'b0};
        end
    end

    // Sweep setup values and cell counters
    logic signed [PW-1:0] r_xhi, r_xlo, r_yhi, r_ylo;
    logic signed [PW-1:0] r_x2_start, r_x2, r_y2, r_step;
    logic [SQ_W-1:0]      r_rr;
    logic [CW-1:0]        r_j;
    logic [RW-1:0]        r_i;
    logic [AW-1:0]        r_row_base;
    logic                 last_col, last_row;
    logic signed [PW-1:0] x2_first;

    assign last_col = (UW'(r_j) + UW'(1)) == nc;
    assign last_row = (UW'(r_i) + UW'(1)) == nr;
    assign x2_first = (PW'(r_origin_x) <<< 1) + $signed(PW'(r_cell_size));

    always_ff @(posedge i_clk) begin
        if (r_state == S_SETUP) begin
            r_xhi      <= r_cx2 + $signed(PW'(r_w));
            r_xlo      <= r_cx2 - $signed(PW'(r_w));
            r_yhi      <= r_cy2 + $signed(PW'(r_h));
            r_ylo      <= r_cy2 - $signed(PW'(r_h));
            r_rr       <= r_r2 * r_r2;
            r_step     <= $signed(PW'(r_cell_size)) <<< 1;
            r_x2_start <= x2_first;
            r_x2       <= x2_first;
            r_y2       <= (PW'(r_origin_y) <<< 1) + $signed(PW'(r_cell_size));
            r_j        <= '0;
            r_i        <= '0;
            r_row_base <= '0;
        end else if (r_state == S_SWEEP) begin
            if (last_col) begin
                r_j        <= '0;
                r_x2       <= r_x2_start;
                r_i        <= r_i + RW'(1);
                r_y2       <= r_y2 + r_step;
                r_row_base <= r_row_base + AW'(MAX_COLS);
            end else begin
                r_j  <= r_j + CW'(1);
                r_x2 <= r_x2 + r_step;
            end
        end
    end

    // Stage 1: distances from the shape center and rectangle test
    logic signed [PW-1:0] xd_pos, xd_neg, yd_pos, yd_neg;
    logic                 r_s1_v, r_s1_rect;
    logic [PW-1:0]        r_s1_dx, r_s1_dy;
    logic [AW-1:0]        r_s1_addr;

    assign xd_pos = r_x2 - r_cx2;
    assign xd_neg = r_cx2 - r_x2;
    assign yd_pos = r_y2 - r_cy2;
    assign yd_neg = r_cy2 - r_y2;

    always_ff @(posedge i_clk) begin
        r_s1_dx   <= xd_pos[PW-1] ? xd_neg : xd_pos;
        r_s1_dy   <= yd_pos[PW-1] ? yd_neg : yd_pos;
        r_s1_rect <= (r_x2 < r_xhi) && (r_x2 > r_xlo) && (r_y2 < r_yhi) && (r_y2 > r_ylo);
        r_s1_addr <= r_row_base + AW'(r_j);
    end

    // Stage 2: squares and bounding box of the circle
    logic [SQ_W-1:0] dxsq, dysq;
    logic            r_s2_v, r_s2_rect, r_s2_inx, r_s2_iny;
    logic [SQ_W-1:0] r_s2_dxsq, r_s2_dysq;
    logic [AW-1:0]   r_s2_addr;

    assign dxsq = r_s1_dx[R2_W-1:0] * r_s1_dx[R2_W-1:0];
    assign dysq = r_s1_dy[R2_W-1:0] * r_s1_dy[R2_W-1:0];

    always_ff @(posedge i_clk) begin
        r_s2_inx  <= r_s1_dx < PW'(r_r2);
        r_s2_iny  <= r_s1_dy < PW'(r_r2);
        r_s2_dxsq <= dxsq;
        r_s2_dysq <= dysq;
        r_s2_rect <= r_s1_rect;
        r_s2_addr <= r_s1_addr;
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            r_s1_v <= (r_state == S_SWEEP);
            r_s2_v <= r_s1_v;
        end
    end

    // Stage 3: final hit decision (dy < r2 keeps rr - dy^2 from wrapping)
    logic hit;
    assign hit = r_is_rect ? r_s2_rect
               : (r_s2_inx && r_s2_iny && (r_s2_dxsq < (r_rr - r_s2_dysq)));

    // Cell memory write port
    logic [AW-1:0] r_clr_addr;
    logic          mem_we, mem_wdata;
    logic [AW-1:0] mem_waddr;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = 1'b0;
        if (r_state == S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_s2_v) begin
            mem_we    = hit;
            mem_waddr = r_s2_addr;
            mem_wdata = 1'b1;
        end else if (acc && i_cmd.cmd == CMD_SET && cell_in_range) begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr;
            mem_wdata = i_cmd.occ;
        end
    end

    // Cell memory
    logic mem [DEPTH];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (acc && i_cmd.cmd == CMD_QUERY) begin
            r_rdata <= mem[cell_addr];
        end
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (r_state == S_CLEAR) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Control sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (acc && !is_cell) n_state = S_SETUP;
            end
            S_SETUP: begin
                if (nc == '0 || nr == '0) n_state = S_DRAIN;
                else                      n_state = S_SWEEP;
            end
            S_SWEEP: begin
                if (last_col && last_row) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_s1_v && !r_s2_v) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Result strobe
    logic r_out_valid, r_out_in_range, r_out_query;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= (acc && is_cell)
                        || (r_state == S_DRAIN && !r_s1_v && !r_s2_v);
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && is_cell) begin
            r_out_in_range <= cell_in_range;
            r_out_query    <= (i_cmd.cmd == CMD_QUERY) && cell_in_range;
        end else if (r_state == S_DRAIN) begin
            r_out_in_range <= 1'b1;
            r_out_query    <= 1'b0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result.occupied = r_out_valid && r_out_query && r_rdata;
    assign o_result.in_range = r_out_in_range;

`ifndef SYNTHESIS
    // A cell command is answered in the next cycle
    a_cell_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd.cmd == CMD_SET || i_cmd.cmd == CMD_QUERY) |=> o_valid)
        else $error("cell command not answered in next cycle");

    // A shape command holds the block busy with no early result
    a_shape_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd.cmd == CMD_RECT || i_cmd.cmd == CMD_CIRCLE)
        |=> busy && !o_valid)
        else $error("shape command did not start a sweep");

    // Sweep writes happen only during a sweep or its drain
    a_sweep_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_v |-> (r_state == S_SWEEP || r_state == S_DRAIN))
        else $error("pipeline write outside sweep");

    // An occupied answer implies an in-range cell
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.occupied |-> o_result.in_range)
        else $error("occupied reported for out-of-range cell");
`endif

endmodule

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ogsr_pkg::*;

    // One world unit in Q15.16
    localparam int Q_ONE = 1 << 16;
    localparam int unsigned MAP_CELLS = DEF_MAX_COLS * DEF_MAX_ROWS;
    localparam int unsigned DRAIN_CAP = 20000;

    // Results that can be read off directly: set/query in range, and out of range
    localparam t_result RES_IN  = '{occupied: 1'b0, in_range: 1'b1};
    localparam t_result RES_OUT = '{occupied: 1'b0, in_range: 1'b0};

    typedef enum logic {PLAN_CMD, PLAN_REG} t_plan_kind_e;

    typedef struct {
        t_plan_kind_e           kind;
        logic [CFG_IDX_W-1:0]   reg_idx;
        logic [CFG_DATA_W-1:0]  reg_data;
        t_cmd_in                item;
        bit                     typed;
        t_result                want;
    } t_plan_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_cmd_in                i_cmd;
    logic                   o_valid;
    t_result                o_result;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // Shadow copy of the grid and its registers
    bit          occ_map [MAP_CELLS];
    int unsigned live_cols = DEF_MAX_COLS;
    int unsigned live_rows = DEF_MAX_ROWS;
    longint      org_x     = 0;
    longint      org_y     = 0;
    longint      cell_len  = 65536;

    t_result     results_due [$];
    t_plan_row   plan [$];
    int unsigned mismatches    = 0;
    int unsigned results_seen  = 0;
    int unsigned items_sent    = 0;
    int unsigned shapes_sent   = 0;
    int unsigned setups_run    = 0;
    int unsigned burst_left    = 0;

    occupancy_grid_shape_raster DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_valid    (o_valid),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void flag(input string what);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t ns: %s", $time, what);
        end
    endfunction

    // Apply one command to the shadow grid and return its result.
    // Shape tests run on doubled coordinates so cell centers stay integral.
    function automatic t_result grid_apply(input t_cmd_in c);
        t_result         res;
        int unsigned     i, j;
        longint          cx2, cy2, w, h, x2, y2;
        longint unsigned rad2, dx, dy, rr;
        bit              hit;
        res.occupied = 1'b0;
        res.in_range = 1'b1;
        if (c.cmd == CMD_SET || c.cmd == CMD_QUERY) begin
            if (c.row < live_rows && c.col < live_cols) begin
                if (c.cmd == CMD_SET) begin
                    occ_map[c.row * DEF_MAX_COLS + c.col] = c.occ;
                end else begin
                    res.occupied = occ_map[c.row * DEF_MAX_COLS + c.col];
                end
            end else begin
                res.in_range = 1'b0;
            end
        end else begin
            cx2  = 2 * longint'($signed(c.center_x));
            cy2  = 2 * longint'($signed(c.center_y));
            w    = longint'(c.rect_width);
            h    = longint'(c.rect_height);
            rad2 = 2 * longint'(c.radius);
            for (i = 0; i < live_rows; i++) begin
                y2 = 2 * org_y + longint'(2 * i + 1) * cell_len;
                for (j = 0; j < live_cols; j++) begin
                    x2 = 2 * org_x + longint'(2 * j + 1) * cell_len;
                    if (c.cmd == CMD_RECT) begin
                        hit = x2 < cx2 + w && x2 > cx2 - w && y2 < cy2 + h && y2 > cy2 - h;
                    end else begin
                        dx  = (x2 < cx2) ? cx2 - x2 : x2 - cx2;
                        dy  = (y2 < cy2) ? cy2 - y2 : y2 - cy2;
                        hit = 1'b0;
                        if (dx < rad2 && dy < rad2) begin
                            rr  = rad2 * rad2;
                            hit = dx * dx < rr - dy * dy;
                        end
                    end
                    if (hit) begin
                        occ_map[i * DEF_MAX_COLS + j] = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    // Stimulus table builders
    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        t_plan_row r;
        r = '{kind: PLAN_REG, reg_idx: idx, reg_data: data, item: '0, typed: 1'b0, want: '0};
        plan.push_back(r);
    endfunction

    function automatic void add_cell(input t_cmd_e op, input int unsigned row,
                                     input int unsigned col, input bit occ,
                                     input bit typed, input t_result want);
        t_plan_row r;
        r = '{kind: PLAN_CMD, reg_idx: '0, reg_data: '0, item: '0, typed: typed, want: want};
        r.item.cmd = op;
        r.item.row = row[CELL_W-1:0];
        r.item.col = col[CELL_W-1:0];
        r.item.occ = occ;
        plan.push_back(r);
    endfunction

    function automatic void add_shape(input t_cmd_e op, input logic signed [31:0] cx,
                                      input logic signed [31:0] cy, input logic [30:0] w,
                                      input logic [30:0] h, input logic [30:0] rad);
        t_plan_row r;
        r = '{kind: PLAN_CMD, reg_idx: '0, reg_data: '0, item: '0, typed: 1'b0, want: RES_IN};
        r.item.cmd         = op;
        r.item.center_x    = cx;
        r.item.center_y    = cy;
        r.item.rect_width  = w;
        r.item.rect_height = h;
        r.item.radius      = rad;
        plan.push_back(r);
    endfunction

    // Shape coordinates on half-cell steps around the grid in use
    function automatic logic [31:0] aim_coord(input longint base, input int unsigned n);
        return 32'(base + longint'($urandom_range(0, 2 * n)) * cell_len / 2
                   + (($urandom_range(0, 3) == 0) ? 1 : 0));
    endfunction

    function automatic logic [30:0] aim_extent(input int unsigned n);
        longint v;
        v = longint'($urandom_range(0, 2 * n + 2)) * cell_len / 2;
        if ($urandom_range(0, 3) == 0) begin
            v = longint'($urandom & 32'h7FFF_FFFF);
        end
        return (v > 64'sh7FFF_FFFF) ? 31'h7FFF_FFFF : 31'(v);
    endfunction

    // Mostly well-aimed commands, the rest raw bits
    function automatic t_cmd_in random_item();
        t_cmd_in     c;
        int unsigned pick;
        pick  = $urandom_range(0, 99);
        c.cmd = (pick < 30) ? CMD_SET : (pick < 65) ? CMD_QUERY :
                (pick < 82) ? CMD_RECT : CMD_CIRCLE;
        c.row = ($urandom_range(0, 3) != 0 && live_rows != 0) ?
                6'($urandom_range(0, live_rows - 1)) : 6'($urandom);
        c.col = ($urandom_range(0, 3) != 0 && live_cols != 0) ?
                6'($urandom_range(0, live_cols - 1)) : 6'($urandom);
        c.occ = 1'($urandom);
        if ($urandom_range(0, 9) < 7) begin
            c.center_x = aim_coord(org_x, live_cols);
            c.center_y = aim_coord(org_y, live_rows);
        end else begin
            c.center_x = $urandom;
            c.center_y = $urandom;
        end
        c.rect_width  = aim_extent(live_cols);
        c.rect_height = aim_extent(live_rows);
        c.radius      = aim_extent((live_cols > live_rows) ? live_cols : live_rows);
        return c;
    endfunction

    // Register write; called at a falling edge while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_GRID_WIDTH: begin
                live_cols = (data[6:0] > DEF_MAX_COLS) ? DEF_MAX_COLS : data[6:0];
            end
            REG_GRID_HEIGHT: begin
                live_rows = (data[6:0] > DEF_MAX_ROWS) ? DEF_MAX_ROWS : data[6:0];
            end
            REG_ORIGIN_X:  org_x    = longint'($signed(data));
            REG_ORIGIN_Y:  org_y    = longint'($signed(data));
            REG_CELL_SIZE: cell_len = longint'(data[30:0]);
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Command transfer in bursts with random gaps; returns at a falling edge
    task automatic send(input t_cmd_in c, input bit typed, input t_result want);
        int unsigned gap;
        t_result     due;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        due = grid_apply(c);
        results_due.push_back(typed ? want : due);
        items_sent++;
        if (c.cmd == CMD_RECT || c.cmd == CMD_CIRCLE) begin
            shapes_sent++;
        end
        @(negedge i_clk);
    endtask

    // Hold off until every owed result is in and the sweep has finished
    task automatic settle();
        int unsigned waited;
        start      <= 1'b0;
        burst_left = 0;
        waited     = 0;
        do begin
            @(negedge i_clk);
            waited++;
        end while ((results_due.size() != 0 || busy) && waited < DRAIN_CAP);
        repeat (4) @(negedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (results_due.size() == 0) begin
                flag($sformatf("unexpected result occupied %b in_range %b",
                               o_result.occupied, o_result.in_range));
            end else begin
                want = results_due.pop_front();
                if (o_result.occupied !== want.occupied ||
                    o_result.in_range !== want.in_range) begin
                    flag($sformatf("occupied exp %b got %b, in_range exp %b got %b",
                                   want.occupied, o_result.occupied,
                                   want.in_range, o_result.in_range));
                end
            end
        end
    end

    initial begin : stimulus
        t_cmd_in     item;
        int unsigned phase;
        logic [31:0] gw, gh, ox, oy, cs;
        start      = 1'b0;
        i_cmd      = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;

        // Fresh grid reads back clear at both corners
        add_cell(CMD_QUERY, 0, 0, 1'b0, 1'b1, RES_IN);
        add_cell(CMD_QUERY, 63, 63, 1'b0, 1'b1, RES_IN);
        // Corner writes, read back, then clear one again
        add_cell(CMD_SET, 0, 0, 1'b1, 1'b1, RES_IN);
        add_cell(CMD_SET, 63, 63, 1'b1, 1'b1, RES_IN);
        add_cell(CMD_QUERY, 0, 0, 1'b0, 1'b0, RES_IN);
        add_cell(CMD_QUERY, 63, 63, 1'b0, 1'b0, RES_IN);
        add_cell(CMD_SET, 0, 0, 1'b0, 1'b1, RES_IN);
        add_cell(CMD_QUERY, 0, 0, 1'b0, 1'b0, RES_IN);
        // Shapes on the default grid, empty ones and extreme ones
        add_shape(CMD_RECT, 10 * Q_ONE, 20 * Q_ONE, 4 * Q_ONE, 2 * Q_ONE, 0);
        add_cell(CMD_QUERY, 20, 10, 1'b0, 1'b0, RES_IN);
        add_shape(CMD_RECT, 5 * Q_ONE, 5 * Q_ONE, 0, 8 * Q_ONE, 0);
        add_shape(CMD_CIRCLE, 32 * Q_ONE, 32 * Q_ONE, 0, 0, 5 * Q_ONE);
        add_cell(CMD_QUERY, 32, 32, 1'b0, 1'b0, RES_IN);
        add_shape(CMD_CIRCLE, 40 * Q_ONE, 40 * Q_ONE, 0, 0, 0);
        add_shape(CMD_RECT, 32'sh8000_0000, 32'sh8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
        add_shape(CMD_CIRCLE, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 0, 31'h7FFF_FFFF);
        add_cell(CMD_QUERY, 50, 60, 1'b0, 1'b0, RES_IN);
        // No columns: every cell is out of range, shapes mark nothing
        add_reg(REG_GRID_WIDTH, 0);
        add_cell(CMD_SET, 0, 0, 1'b1, 1'b1, RES_OUT);
        add_cell(CMD_QUERY, 0, 0, 1'b0, 1'b1, RES_OUT);
        add_shape(CMD_RECT, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
        // Width past storage, five rows, shifted origin, half-unit cells
        add_reg(REG_GRID_WIDTH, 127);
        add_reg(REG_GRID_HEIGHT, 5);
        add_reg(REG_ORIGIN_X, -(5 * Q_ONE / 2));
        add_reg(REG_ORIGIN_Y, 3 * Q_ONE);
        add_reg(REG_CELL_SIZE, Q_ONE / 2);
        add_cell(CMD_QUERY, 10, 3, 1'b0, 1'b1, RES_OUT);
        add_cell(CMD_QUERY, 4, 63, 1'b0, 1'b0, RES_IN);
        add_shape(CMD_CIRCLE, 8 * Q_ONE, 4 * Q_ONE, 0, 0, 3 * Q_ONE);
        add_shape(CMD_RECT, 0, 4 * Q_ONE, 6 * Q_ONE, Q_ONE, 0);
        // Zero cell size: all centers sit on the origin
        add_reg(REG_CELL_SIZE, 0);
        add_shape(CMD_RECT, -(5 * Q_ONE / 2), 3 * Q_ONE, 1, 1, 0);

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        // Wait out the clearing pass
        repeat (2) @(negedge i_clk);
        while (busy) @(negedge i_clk);

        foreach (plan[k]) begin
            if (plan[k].kind == PLAN_REG) begin
                settle();
                write_reg(plan[k].reg_idx, plan[k].reg_data);
            end else begin
                send(plan[k].item, plan[k].typed, plan[k].want);
            end
        end

        // Random commands over several grid setups, full size only once
        for (phase = 0; phase < 7; phase++) begin
            settle();
            case (phase)
                0: begin
                    gw = 64; gh = 64; ox = 0; oy = 0; cs = Q_ONE;
                end
                1: begin
                    gw = 127; gh = 1; ox = 32'h8000_0000; oy = 32'h7FFF_FFFF;
                    cs = 32'h7FFF_FFFF;
                end
                2: begin
                    gw = 1; gh = 127; ox = $urandom; oy = $urandom; cs = 0;
                end
                3: begin
                    gw = 0; gh = $urandom_range(1, 8); ox = 0; oy = 0; cs = Q_ONE;
                end
                default: begin
                    gw = $urandom_range(1, 16);
                    gh = $urandom_range(1, 16);
                    ox = ($urandom_range(0, 1) != 0) ? $urandom :
                         $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                    oy = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                    case ($urandom_range(0, 2))
                        0:       cs = 1;
                        1:       cs = $urandom_range(1, 32'h0004_0000);
                        default: cs = $urandom & 32'h7FFF_FFFF;
                    endcase
                end
            endcase
            write_reg(REG_GRID_WIDTH, gw);
            write_reg(REG_GRID_HEIGHT, gh);
            write_reg(REG_ORIGIN_X, ox);
            write_reg(REG_ORIGIN_Y, oy);
            write_reg(REG_CELL_SIZE, cs);
            setups_run++;
            repeat (16) begin
                item = random_item();
                send(item, 1'b0, RES_IN);
            end
        end

        settle();
        repeat (10) @(negedge i_clk);
        if (results_due.size() != 0) begin
            flag($sformatf("%0d results never arrived", results_due.size()));
        end

        $display("covered %0d commands (%0d shape sweeps) over %0d random grid setups",
                 items_sent, shapes_sent, setups_run);
        $display("%0d results checked, %0d mismatches", results_seen, mismatches);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #20ms;
        $display("timeout with %0d results outstanding", results_due.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: occupancy_grid_shape_raster.f
hdl/ogsr_pkg.sv
hdl/occupancy_grid_shape_raster.sv
sim/tb.sv
